// ===== hdl/aas_pkg.sv =====
// Package for the aging address set: status codes, register map and defaults.
// Used by aging_address_set; depends on nothing else.
`default_nettype none

package aas_pkg;

  // Status codes carried on out_status
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_REFRESHED = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NONE      = 3'd4;

  // Opcodes carried on in_opcode
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SWEEP = 1'b1;

  // Defaults for the top-level parameters
  localparam int CAPACITY_DEF   = 64;
  localparam int EPOCH_BITS_DEF = 16;

  // Register map: address_bytes is register 0
  localparam logic [3:0] ADDRESS_BYTES_RST = 4'd6;
  localparam int         ADDR_W            = 64;
  localparam int         PADDR_W           = 2;

  // Byte mask for the compared width; zero acts as one byte, above eight as eight
  function automatic logic [ADDR_W-1:0] width_mask(input logic [3:0] n);
    logic [ADDR_W-1:0] m;
    logic [3:0]        eff;
    eff = (n == 4'd0) ? 4'd1 : n;
    m   = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < eff) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/aging_address_set.sv =====
// Aging address set: table of addresses stamped with the epoch last seen.
// Holds the scan sequencer, entry memories and valid flags; uses aas_pkg.
`default_nettype none

// Channel  | Ports                                          | Direction
// ---------+------------------------------------------------+----------
// input    | in_valid, in_stall, in_opcode, in_address,     | in
//          | in_current_epoch                               |
// result   | out_valid, out_stall, out_status,              | out
//          | out_address_out, out_last_of_run               |
// config   | psel, penable, pwrite, paddr, pwdata, prdata,  | APB
//          | pready (address_bytes at byte address 0)       |
//
// Each item walks the entries through one memory read port and one shared
// compare: in_stall is high from the transfer until the item's result is
// loaded (a read-ahead step, one compare per entry, a report step), so the
// block takes no new input item before the last one is through. An add that
// finds its address stops at that entry. A result still held by out_stall when
// the next one is ready freezes the scan for as long as it waits.
// Reset clears the valid flags at once; there is no clearing pass.

module aging_address_set
  import aas_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int EPOCH_BITS = EPOCH_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_opcode,
  input  wire logic [63:0]        in_address,
  input  wire logic [15:0]        in_current_epoch,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_status,
  output logic [63:0]             out_address_out,
  output logic                    out_last_of_run,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // configuration register
  logic [3:0] addr_bytes_r;

  // entry storage
  logic [CAPACITY-1:0]   entry_valid_r;
  logic [ADDR_W-1:0]     entry_address_mem [CAPACITY];
  logic [EPOCH_BITS-1:0] entry_stamp_mem   [CAPACITY];

  // sequencer
  logic [1:0]            state_r, state_nxt;
  logic                  op_r;
  logic [ADDR_W-1:0]     key_r;
  logic [EPOCH_BITS-1:0] now_r;
  logic [IDX_W-1:0]      scan_idx_r;
  logic                  scan_on_r;
  logic                  eval_vld_r;
  logic [IDX_W-1:0]      eval_idx_r;
  logic [ADDR_W-1:0]     rd_addr_r;
  logic [EPOCH_BITS-1:0] rd_stamp_r;
  logic                  free_found_r;
  logic [IDX_W-1:0]      free_idx_r;
  logic                  pend_r;
  logic [ADDR_W-1:0]     pend_addr_r;

  // output register
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_last_r;

  logic [ADDR_W-1:0] mask;
  logic              in_xfer;
  logic              out_free;
  logic              cur_valid;
  logic              hit;
  logic              stale;
  logic              emit;
  logic [2:0]        emit_status;
  logic [ADDR_W-1:0] emit_addr;
  logic              emit_last;
  logic              advance;
  logic              stamp_we;
  logic              add_we;
  logic              clr_valid;

  assign mask      = width_mask(addr_bytes_r);
  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cur_valid = entry_valid_r[eval_idx_r];
  assign hit       = eval_vld_r && cur_valid && ((rd_addr_r & mask) == key_r);
  assign stale     = eval_vld_r && cur_valid && (rd_stamp_r != now_r);

  // Decide what the current step emits, writes and where the sequencer goes
  always_comb begin
    emit        = 1'b0;
    emit_status = ST_NONE;
    emit_addr   = '0;
    emit_last   = 1'b1;
    advance     = 1'b0;
    stamp_we    = 1'b0;
    add_we      = 1'b0;
    clr_valid   = 1'b0;
    state_nxt   = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (op_r == OP_ADD) begin
          if (hit) begin
            emit        = 1'b1;
            emit_status = ST_REFRESHED;
            emit_addr   = key_r;
          end
        end else if (stale && pend_r) begin
          emit        = 1'b1;
          emit_status = ST_REMOVED;
          emit_addr   = pend_addr_r;
          emit_last   = 1'b0;
        end
        // hold the whole scan while a result is due and the result register is occupied
        if (!emit || out_free) begin
          advance = 1'b1;
          if (op_r == OP_ADD && hit) begin
            stamp_we  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            clr_valid = (op_r == OP_SWEEP) && stale;
            if (eval_vld_r && eval_idx_r == LAST_IDX) begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        emit = 1'b1;
        if (op_r == OP_ADD) begin
          emit_addr   = key_r;
          emit_status = free_found_r ? ST_ADDED : ST_FULL;
        end else if (pend_r) begin
          emit_status = ST_REMOVED;
          emit_addr   = pend_addr_r;
        end
        if (out_free) begin
          add_we    = (op_r == OP_ADD) && free_found_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Entry memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (stamp_we) begin
      entry_stamp_mem[eval_idx_r] <= now_r;
    end
    if (add_we) begin
      entry_stamp_mem[free_idx_r]   <= now_r;
      entry_address_mem[free_idx_r] <= key_r;
    end
    if (advance && scan_on_r) begin
      rd_addr_r  <= entry_address_mem[scan_idx_r];
      rd_stamp_r <= entry_stamp_mem[scan_idx_r];
    end
  end

  // Sequencer control and valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_valid_r <= '0;
      scan_on_r     <= 1'b0;
      eval_vld_r    <= 1'b0;
      free_found_r  <= 1'b0;
      pend_r        <= 1'b0;
      addr_bytes_r  <= ADDRESS_BYTES_RST;
    end else begin
      state_r <= state_nxt;
      if (psel && penable && pwrite && pready) begin
        addr_bytes_r <= pwdata[3:0];
      end
      if (in_xfer) begin
        scan_on_r    <= 1'b1;
        eval_vld_r   <= 1'b0;
        free_found_r <= 1'b0;
        pend_r       <= 1'b0;
      end else if (advance) begin
        eval_vld_r <= scan_on_r;
        if (scan_on_r && scan_idx_r == LAST_IDX) begin
          scan_on_r <= 1'b0;
        end
        // remember the lowest free slot for a later add
        if (op_r == OP_ADD && eval_vld_r && !cur_valid && !free_found_r) begin
          free_found_r <= 1'b1;
        end
        if (clr_valid) begin
          pend_r <= 1'b1;
        end
      end
      if (clr_valid) begin
        entry_valid_r[eval_idx_r] <= 1'b0;
      end
      if (add_we) begin
        entry_valid_r[free_idx_r] <= 1'b1;
      end
    end
  end

  // Sequencer payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r       <= in_opcode;
      key_r      <= in_address & mask;
      now_r      <= EPOCH_BITS'(in_current_epoch);
      scan_idx_r <= '0;
    end else if (advance) begin
      if (scan_on_r && scan_idx_r != LAST_IDX) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
      if (scan_on_r) begin
        eval_idx_r <= scan_idx_r;
      end
      if (op_r == OP_ADD && eval_vld_r && !cur_valid && !free_found_r) begin
        free_idx_r <= eval_idx_r;
      end
      if (clr_valid) begin
        pend_addr_r <= rd_addr_r;
      end
    end
  end

  // Result register: load on emit, drop once the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      out_status_r <= emit_status;
      out_addr_r   <= emit_addr;
      out_last_r   <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_address_out = out_addr_r;
  assign out_last_of_run = out_last_r;

  // Configuration reads; paddr decodes to the one register
  assign prdata = {28'd0, addr_bytes_r} | {30'd0, paddr & 2'b00};
  assign pready = 1'b1;

endmodule

`default_nettype wire
